// ===== hdl/seq_pkg.sv =====
// shared types and codes for the sorted event queue
package seq_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_APPEND = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [15:0] process_id;
        logic [31:0] arrival_time;
        logic [31:0] cpu_time;
    } t_rec;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic push;
        logic sorted;
        logic pop;
        t_rec rec;
    } t_cmd;

endpackage

// ===== hdl/seq_cell.sv =====
// one slot of the queue chain with its key compare and shift select
module seq_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic               i_clk,
    input  seq_pkg::t_cmd      i_cmd,
    input  logic [CW-1:0]      i_count,
    input  logic               i_found,
    input  seq_pkg::t_rec      i_left,
    input  seq_pkg::t_rec      i_right,
    output logic               o_found,
    output seq_pkg::t_rec      o_rec
);

    seq_pkg::t_rec r_rec;
    seq_pkg::t_rec n_rec;
    logic          occ;
    logic          at_tail;
    logic          le;

    assign occ     = (32'(i_count) > 32'(IDX));
    assign at_tail = (32'(i_count) == 32'(IDX));
    assign le      = i_cmd.sorted && occ
                     && (i_cmd.rec.arrival_time <= r_rec.arrival_time);
    assign o_found = i_found | le;
    assign o_rec   = r_rec;

    always_comb begin
        n_rec = r_rec;
        if (i_cmd.push) begin
            if (i_found) begin
                n_rec = i_left;
            end else if (le || at_tail) begin
                n_rec = i_cmd.rec;
            end
        end else if (i_cmd.pop) begin
            n_rec = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule

// ===== hdl/sorted_event_queue.sv =====
// top level of the sorted event queue
//
// one operation per transfer: start with busy low takes i_op and the record
// fields. op insert places the record ahead of the first stored entry whose
// arrival time is greater or equal, append places it at the tail, pop
// returns the head entry.
// the result is shown on the o_ ports for exactly one cycle with o_done
// high, in the cycle after the transfer; the receiver cannot stall it.
// busy stays low, so a new operation may be started in every cycle:
// throughput 1 operation per cycle. all slot cells compare their keys
// against the new arrival time in the same cycle and a found flag ripples
// through the chain to pick the insert point.
// insert or append on a full queue answers status full, pop on an empty
// queue answers status empty with zero record fields.
// o_fill_count gives the entry count after the operation, low 5 bits.
// synchronous reset empties the queue and clears o_done; slot contents are
// not cleared and are never shown before being written.
module sorted_event_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_process_id,
    input  logic [31:0] i_arrival_time,
    input  logic [31:0] i_cpu_time,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic        o_out_valid,
    output logic [15:0] o_out_process_id,
    output logic [31:0] o_out_arrival_time,
    output logic [31:0] o_out_cpu_time,
    output logic [4:0]  o_fill_count
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic               accept;
    logic               full;
    logic               empty;
    seq_pkg::t_op       op;
    seq_pkg::t_cmd      cmd;
    seq_pkg::t_rec      w_rec [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_found;

    logic               r_done;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    seq_pkg::t_status   r_status;
    seq_pkg::t_status   n_status;
    logic               r_valid;
    logic               n_valid;
    seq_pkg::t_rec      r_out;
    seq_pkg::t_rec      n_out;
    logic [31:0]        cnt_ext;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign op     = seq_pkg::t_op'(i_op);
    assign full   = (r_count == CW'(QUEUE_DEPTH));
    assign empty  = (r_count == '0);

    always_comb begin
        cmd.rec.process_id   = i_process_id;
        cmd.rec.arrival_time = i_arrival_time;
        cmd.rec.cpu_time     = i_cpu_time;
        cmd.sorted = accept && (op == seq_pkg::OP_INSERT) && !full;
        cmd.push   = accept && (op == seq_pkg::OP_INSERT || op == seq_pkg::OP_APPEND)
                     && !full;
        cmd.pop    = accept && (op == seq_pkg::OP_POP) && !empty;
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        seq_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_count (r_count),
            .i_found ((g == 0) ? 1'b0 : w_found[(g == 0) ? 0 : g - 1]),
            .i_left  (w_rec[(g == 0) ? 0 : g - 1]),
            .i_right (w_rec[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
            .o_found (w_found[g]),
            .o_rec   (w_rec[g])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_status = seq_pkg::ST_OK;
        n_valid  = 1'b0;
        n_out    = '0;
        case (op)
            seq_pkg::OP_INSERT, seq_pkg::OP_APPEND: begin
                if (full) begin
                    n_status = seq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            seq_pkg::OP_POP: begin
                if (empty) begin
                    n_status = seq_pkg::ST_EMPTY;
                end else begin
                    n_valid = 1'b1;
                    n_out   = w_rec[0];
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_valid  <= n_valid;
            r_out    <= n_out;
        end
    end

    assign cnt_ext            = 32'(r_count);
    assign o_done             = r_done;
    assign o_status           = r_status;
    assign o_out_valid        = r_valid;
    assign o_out_process_id   = r_out.process_id;
    assign o_out_arrival_time = r_out.arrival_time;
    assign o_out_cpu_time     = r_out.cpu_time;
    assign o_fill_count       = cnt_ext[4:0];

endmodule

// ===== hdl/seq_checker.sv =====
// port checks for the sorted event queue and their bind
module seq_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [1:0]  o_status,
    input logic        o_out_valid,
    input logic [15:0] o_out_process_id,
    input logic [31:0] o_out_arrival_time,
    input logic [31:0] o_out_cpu_time,
    input logic [4:0]  o_fill_count
);

    localparam logic [31:0] DEPTH_EXT = 32'(QUEUE_DEPTH);

    // every transfer yields one result in the next cycle
    a_done_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("missing result after transfer");

    a_no_spurious_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_done)
        else $error("result without transfer");

    a_empty_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_out_valid) |->
        (o_out_process_id == '0 && o_out_arrival_time == '0 && o_out_cpu_time == '0))
        else $error("record fields not zero without popped record");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == seq_pkg::ST_FULL) |-> (o_fill_count == DEPTH_EXT[4:0]))
        else $error("full status with queue not full");

    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out_valid) |-> (o_status == seq_pkg::ST_OK))
        else $error("popped record with bad status");

endmodule

bind sorted_event_queue seq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_seq_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .o_done             (o_done),
    .o_status           (o_status),
    .o_out_valid        (o_out_valid),
    .o_out_process_id   (o_out_process_id),
    .o_out_arrival_time (o_out_arrival_time),
    .o_out_cpu_time     (o_out_cpu_time),
    .o_fill_count       (o_fill_count)
);
